// ----- hdl/gapped_sorted_table_min_pop_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sorted table
// Shared property wrappers used by the top level checks.
// ----------------------------------------------------------------------------
`ifndef GAPPED_SORTED_TABLE_MIN_POP_TOP_DEFINES_SVH
`define GAPPED_SORTED_TABLE_MIN_POP_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define GSTMP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define GSTMP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/gstmp_pkg.sv -----
// ----------------------------------------------------------------------------
// gstmp_pkg
// Types and constants shared by the sorted table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gstmp_pkg;

  localparam int CAPACITY  = 64;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int TIME_W    = 30;
  localparam int COUNT_W   = 31;
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 3;
  localparam logic [TIME_W-1:0] GAP_RESET = TIME_W'(30);

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_POP    = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 3'd0,
    ST_NONE  = 3'd1,
    ST_DUP   = 3'd2,
    ST_CLOSE = 3'd3,
    ST_FULL  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_CHK_NEXT,
    S_CHK_PREV,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_POP_START,
    S_POP_CNT,
    S_POP_RD,
    S_POP_WR,
    S_DONE
  } state_t;

  // table port request: one write, one registered read per cycle
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [TIME_W-1:0]  wtime;
    logic [COUNT_W-1:0] wcount;
    logic [IDX_W-1:0]   raddr;
  } mem_req_t;

  // compare unit flags
  typedef struct packed {
    logic lt;      // a < b
    logic eq;      // a == b
    logic le_gap;  // a - b <= gap, meaningful when a >= b
  } alu_res_t;

  // sequencer status seen by the top level
  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] total;
  } ctrl_stat_t;

endpackage

`default_nettype wire

// ----- hdl/gstmp_alu.sv -----
// ----------------------------------------------------------------------------
// gstmp_alu
// Shared subtract/compare unit: order, equality and distance against gap.
// ----------------------------------------------------------------------------
`default_nettype none

module gstmp_alu
  import gstmp_pkg::*;
(
  input  wire logic [TIME_W-1:0] a,
  input  wire logic [TIME_W-1:0] b,
  input  wire logic [TIME_W-1:0] gap,
  output alu_res_t               res
);

  logic [TIME_W:0] diff;

  assign diff       = {1'b0, a} - {1'b0, b};
  assign res.lt     = diff[TIME_W];
  assign res.eq     = (a == b);
  assign res.le_gap = (diff[TIME_W-1:0] <= gap);

endmodule

`default_nettype wire

// ----- hdl/gstmp_store.sv -----
// ----------------------------------------------------------------------------
// gstmp_store
// Entry storage: time and count arrays, one write and one read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gstmp_store
  import gstmp_pkg::*;
(
  input  wire logic               clk,
  input  wire mem_req_t           req,
  output logic      [TIME_W-1:0]  rd_time,
  output logic      [COUNT_W-1:0] rd_count
);

  logic [TIME_W-1:0]  times  [CAPACITY];
  logic [COUNT_W-1:0] counts [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      times[req.waddr]  <= req.wtime;
      counts[req.waddr] <= req.wcount;
    end
  end

  always_ff @(posedge clk) begin
    rd_time  <= times[req.raddr];
    rd_count <= counts[req.raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/gstmp_ctrl.sv -----
// ----------------------------------------------------------------------------
// gstmp_ctrl
// Request sequencer: scans, checks, shifts the table up on insert or down on pop, and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module gstmp_ctrl
  import gstmp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // request side
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire logic [ACT_W-1:0]   req_action,
  input  wire logic [TIME_W-1:0]  req_key,
  input  wire logic [COUNT_W-1:0] req_count,
  // compare unit
  output logic      [TIME_W-1:0]  alu_a,
  output logic      [TIME_W-1:0]  alu_b,
  input  wire alu_res_t           alu_res,
  // table
  output mem_req_t                mem_req,
  input  wire logic [TIME_W-1:0]  rd_time,
  input  wire logic [COUNT_W-1:0] rd_count,
  // result side
  output logic                    res_valid,
  input  wire logic               res_ready,
  output logic      [COUNT_W-1:0] res_count,
  output logic      [STAT_W-1:0]  res_status,
  output ctrl_stat_t              stat
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

  state_t             state, state_next;
  action_t            act;
  logic [TIME_W-1:0]  key;
  logic [COUNT_W-1:0] cnt;
  logic [CNT_W-1:0]   idx;        // scan position, ends as insert slot
  logic [CNT_W-1:0]   jdx;        // shift position
  logic [CNT_W-1:0]   total;
  logic [TIME_W-1:0]  prev_time;
  logic               have_prev;
  logic [TIME_W-1:0]  next_time;
  logic [COUNT_W-1:0] next_count;
  logic               have_next;
  logic               next_close;
  logic [COUNT_W-1:0] acc_count;
  status_t            acc_status;
  logic               out_free;
  logic               prev_close;
  logic [CNT_W-1:0]   jdx_m1;
  logic [CNT_W-1:0]   idx_m1;

  assign out_free   = !res_valid || res_ready;
  assign prev_close = have_prev && alu_res.le_gap;
  assign jdx_m1     = jdx - ONE;
  assign idx_m1     = idx - ONE;
  assign req_ready  = (state == S_IDLE);
  assign stat.busy  = (state != S_IDLE);
  assign stat.total = total;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (action_t'(req_action))
            ACT_INSERT, ACT_QUERY: state_next = S_SCAN_RD;
            ACT_POP:               state_next = S_POP_START;
            default:               state_next = S_DONE;
          endcase
        end
      end
      S_SCAN_RD:  state_next = (idx == total) ? S_CHK_NEXT : S_SCAN_CMP;
      S_SCAN_CMP: state_next = alu_res.lt ? S_SCAN_RD : S_CHK_NEXT;
      S_CHK_NEXT: begin
        if (act == ACT_INSERT && !(have_next && alu_res.eq)) begin
          state_next = S_CHK_PREV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CHK_PREV: begin
        if (prev_close || next_close || total == CAP_CNT) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD:  state_next = (jdx == idx) ? S_DONE : S_SHIFT_WR;
      S_SHIFT_WR:  state_next = S_SHIFT_RD;
      S_POP_START: state_next = (total == '0) ? S_DONE : S_POP_CNT;
      S_POP_CNT:   state_next = S_POP_RD;
      S_POP_RD:    state_next = (idx >= total) ? S_DONE : S_POP_WR;
      S_POP_WR:    state_next = S_POP_RD;
      S_DONE:      state_next = out_free ? S_IDLE : S_DONE;
      default:     state_next = S_IDLE;
    endcase
  end

  // table port and compare operands
  always_comb begin
    mem_req.we     = 1'b0;
    mem_req.waddr  = idx[IDX_W-1:0];
    mem_req.wtime  = rd_time;
    mem_req.wcount = rd_count;
    mem_req.raddr  = idx[IDX_W-1:0];
    alu_a          = next_time;
    alu_b          = key;
    case (state)
      S_SCAN_CMP: begin
        alu_a = rd_time;
        alu_b = key;
      end
      S_CHK_PREV: begin
        alu_a = key;
        alu_b = prev_time;
      end
      S_SHIFT_RD: begin
        mem_req.raddr = jdx_m1[IDX_W-1:0];
        if (jdx == idx) begin
          mem_req.we     = 1'b1;
          mem_req.waddr  = idx[IDX_W-1:0];
          mem_req.wtime  = key;
          mem_req.wcount = cnt;
        end
      end
      S_SHIFT_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = jdx[IDX_W-1:0];
      end
      S_POP_START: mem_req.raddr = '0;
      S_POP_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_m1[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SHIFT_RD && jdx == idx) begin
        total <= total + ONE;
      end else if (state == S_POP_RD && idx >= total) begin
        total <= total - ONE;
      end
      if (state == S_DONE && out_free) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        act        <= action_t'(req_action);
        key        <= req_key;
        cnt        <= req_count;
        idx        <= '0;
        have_prev  <= 1'b0;
        have_next  <= 1'b0;
        next_close <= 1'b0;
        acc_count  <= '0;
        acc_status <= ST_NONE;
      end
      S_SCAN_CMP: begin
        if (alu_res.lt) begin
          prev_time <= rd_time;
          have_prev <= 1'b1;
          idx       <= idx + ONE;
        end else begin
          next_time  <= rd_time;
          next_count <= rd_count;
          have_next  <= 1'b1;
        end
      end
      S_CHK_NEXT: begin
        if (have_next && alu_res.eq) begin
          if (act == ACT_QUERY) begin
            acc_count  <= next_count;
            acc_status <= ST_OK;
          end else begin
            acc_status <= ST_DUP;
          end
        end
        // next is at or above key here, so the distance has no borrow
        next_close <= have_next && alu_res.le_gap;
      end
      S_CHK_PREV: begin
        jdx <= total;
        if (prev_close || next_close) begin
          acc_status <= ST_CLOSE;
        end else if (total == CAP_CNT) begin
          acc_status <= ST_FULL;
        end
      end
      S_SHIFT_RD: begin
        if (jdx == idx) acc_status <= ST_OK;
      end
      S_SHIFT_WR: jdx <= jdx_m1;
      S_POP_CNT: begin
        acc_count  <= rd_count;
        acc_status <= ST_OK;
        idx        <= ONE;
      end
      S_POP_WR: idx <= idx + ONE;
      S_DONE: begin
        if (out_free) begin
          res_count  <= acc_count;
          res_status <= acc_status;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/gapped_sorted_table_min_pop_top.sv -----
// A sorted table of up to 64 (time, count) entries, kept in rising time order
// in a single-port-write / single-port-read memory, serviced by one sequencer
// and one shared subtract/compare unit. One request is taken at a time; ready
// is low from acceptance until the result is loaded into the output register.
// Work per request, with n entries stored and p entries below the key: a
// query scans past the p lower entries and checks the next one; an insert
// scans, checks the neighbors, then shifts the upper part up one slot; a pop
// moves the whole table down one slot. Each of the scan, shift and pop loops
// pairs a memory read state with a compare or write state. A new request can
// be accepted while the previous result still waits on m_tready.
// ----------------------------------------------------------------------------
// gapped_sorted_table_min_pop_top
// Sorted time table with gap-checked insert, minimum pop and exact lookup.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gapped_sorted_table_min_pop_top_defines.svh"

module gapped_sorted_table_min_pop_top
  import gstmp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // request items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // [29:0] time_key, [60:30] count_in, rest zero
  input  wire logic [1:0]  s_tuser,   // [1:0] action
  // result items
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // [30:0] count_out, [31] zero
  output logic      [2:0]  m_tuser,   // [2:0] status
  // min_gap register write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [29:0] cfg_data
);

  logic [TIME_W-1:0]  min_gap;
  logic [TIME_W-1:0]  alu_a;
  logic [TIME_W-1:0]  alu_b;
  alu_res_t           alu_res;
  mem_req_t           mem_req;
  logic [TIME_W-1:0]  rd_time;
  logic [COUNT_W-1:0] rd_count;
  logic [COUNT_W-1:0] res_count;
  logic [STAT_W-1:0]  res_status;
  ctrl_stat_t         stat;

  // gap register, always writable; it is to be written only while idle, which the block itself does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap <= GAP_RESET;
    end else if (cfg_valid) begin
      min_gap <= cfg_data;
    end
  end

  gstmp_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .gap (min_gap),
    .res (alu_res)
  );

  gstmp_store u_store (
    .clk      (clk),
    .req      (mem_req),
    .rd_time  (rd_time),
    .rd_count (rd_count)
  );

  gstmp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (s_tvalid),
    .req_ready  (s_tready),
    .req_action (s_tuser),
    .req_key    (s_tdata[TIME_W-1:0]),
    .req_count  (s_tdata[TIME_W+COUNT_W-1:TIME_W]),
    .alu_a      (alu_a),
    .alu_b      (alu_b),
    .alu_res    (alu_res),
    .mem_req    (mem_req),
    .rd_time    (rd_time),
    .rd_count   (rd_count),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res_count  (res_count),
    .res_status (res_status),
    .stat       (stat)
  );

  assign m_tdata = {1'b0, res_count};
  assign m_tuser = res_status;

  // fill level never passes the table size
  `GSTMP_ASSERT_NOW(a_total_cap, clk, rst, 1'b1, stat.total <= CNT_W'(CAPACITY),
    "entry count above capacity")
  // a taken request keeps the block busy in the next cycle
  `GSTMP_ASSERT_NXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready,
    stat.busy && !s_tready, "request accepted but block not busy")
  // entry count moves by at most one per cycle
  `GSTMP_ASSERT_NXT(a_total_step, clk, rst, 1'b1,
    stat.total == $past(stat.total) || stat.total == $past(stat.total) + 1 ||
    stat.total == $past(stat.total) - 1, "entry count jumped")

endmodule

`default_nettype wire
